// ----- rtl/isst_pkg.sv -----
// ----------------------------------------------------------------------------
// isst_pkg: shared types and constants of the ID set slot table
// Mode and status codes, register map and field widths used by the table
// core and its register block.
// ----------------------------------------------------------------------------
package isst_pkg;

	// field and bus widths
	localparam int ID_W     = 16;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;
	localparam int SLOTO_W  = 6;
	localparam int COUNTO_W = 7;

	// register index taken from paddr above the byte offset
	typedef logic [ADDR_W-3:0] reg_idx_t;
	localparam reg_idx_t REG_EMPTY_MARKER = reg_idx_t'(0);

	// operation requested by an input transfer
	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_READ   = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	// outcome reported with each result transfer
	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_DUP      = 3'd1,
		ST_FULL     = 3'd2,
		ST_REMOVED  = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_HIT      = 3'd5,
		ST_EMPTY    = 3'd6,
		ST_CLEARED  = 3'd7
	} status_t;

endpackage

// ----- rtl/id_set_slot_table_unit.sv -----
// ----------------------------------------------------------------------------
// id_set_slot_table_unit: fixed slot table holding a set of 16-bit IDs
// Add, remove, read and clear of IDs in a one-read-port slot memory, walked by
// a small sequencer with one shared ID comparator.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_stall stays high until it is finished. An
// add or remove walks every slot through the single memory read port, one
// slot per cycle, before it forms its result. A read waits on one registered
// memory read; a clear runs a wiping pass (one memory write per slot). After
// reset the block runs a clearing pass over every slot before it takes its
// first item; configuration writes are taken throughout. A finished result
// waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module id_set_slot_table_unit
	import isst_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          mode,
	input  logic [ID_W-1:0]     id_value,
	input  logic [SLOTO_W-1:0]  slot_index,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          status,
	output logic [SLOTO_W-1:0]  slot_out,
	output logic [ID_W-1:0]     id_out,
	output logic [COUNTO_W-1:0] entry_count,
	output logic [SLOTO_W-1:0]  high_mark,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready
);

	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [AW:0]   SLOTS_C = (AW + 1)'(SLOTS);
	localparam logic [AW-1:0] LAST_C  = AW'(SLOTS - 1);

	typedef enum logic [2:0] {
		S_WIPE,
		S_IDLE,
		S_SCAN,
		S_RDWAIT,
		S_FIN
	} state_t;

	// memory word: used flag over the stored ID
	typedef logic [ID_W:0] word_t;

	state_t               state_q;
	logic [AW:0]          cnt_q;
	logic                 wipe_clear_q;
	mode_t                mode_q;
	logic [ID_W-1:0]      id_q;
	logic [SLOTO_W-1:0]   sidx_q;
	logic                 found_q;
	logic                 dup_q;
	logic [AW-1:0]        found_idx_q;
	logic [AW-1:0]        hi_q;
	logic [CW-1:0]        count_q;
	logic [AW-1:0]        top_q;
	logic                 vld_s1;
	logic [AW-1:0]        idx_s1;

	logic                 out_valid_q;
	status_t              status_q;
	logic [SLOTO_W-1:0]   slot_q;
	logic [ID_W-1:0]      id_out_q;
	logic [COUNTO_W-1:0]  count_out_q;
	logic [SLOTO_W-1:0]   mark_out_q;

	word_t                mem [SLOTS];
	word_t                mem_rdata;
	logic [AW-1:0]        rd_addr;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	word_t                mem_wdata;

	logic [ID_W-1:0]      empty_marker;
	logic                 scan_issue;
	logic                 rd_used;
	logic                 id_match;
	logic                 fin_fire;
	logic [AW+SLOTO_W-1:0] sidx_ext;
	logic [AW-1:0]        sidx_addr;
	logic                 sidx_in_range;

	// next-step values formed in the finishing cycle
	status_t              fin_status;
	logic [AW-1:0]        fin_slot;
	logic [ID_W-1:0]      fin_id;
	logic [CW-1:0]        fin_count;
	logic [AW-1:0]        fin_top;
	logic [AW+SLOTO_W-1:0] fin_slot_ext;
	logic [AW+SLOTO_W-1:0] fin_top_ext;
	logic [CW+COUNTO_W-1:0] fin_count_ext;

	isst_apb_reg u_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.empty_marker (empty_marker)
	);

	// map the requested slot onto the memory address space
	assign sidx_ext      = (AW + SLOTO_W)'(sidx_q);
	assign sidx_addr     = sidx_ext[AW-1:0];
	assign sidx_in_range = (32'(sidx_q) < SLOTS);

	// issue one slot read per cycle while walking the table
	assign scan_issue = (state_q == S_SCAN) && (cnt_q < SLOTS_C);
	assign rd_addr    = (state_q == S_SCAN) ? cnt_q[AW-1:0] : sidx_addr;

	// shared ID comparator against the word just read
	assign rd_used  = mem_rdata[ID_W];
	assign id_match = rd_used && (mem_rdata[ID_W-1:0] == id_q);

	assign fin_fire = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	assign in_stall = (state_q != S_IDLE);

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata <= mem[rd_addr];
	end

	// select the memory write: clearing pass or the finishing update
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = found_idx_q;
		mem_wdata = '0;
		if (state_q == S_WIPE) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_q[AW-1:0];
		end else if (fin_fire && (mode_q == MODE_ADD) && !dup_q && found_q) begin
			mem_we    = 1'b1;
			mem_wdata = {1'b1, id_q};
		end else if (fin_fire && (mode_q == MODE_REMOVE) && found_q) begin
			mem_we    = 1'b1;
			mem_wdata = {1'b0, empty_marker};
		end
	end

	// form the result and the new count and mark
	always_comb begin
		fin_status = ST_CLEARED;
		fin_slot   = '0;
		fin_id     = '0;
		fin_count  = count_q;
		fin_top    = top_q;
		unique case (mode_q)
			MODE_ADD: begin
				if (dup_q) begin
					fin_status = ST_DUP;
				end else if (found_q) begin
					fin_status = ST_ADDED;
					fin_slot   = found_idx_q;
					fin_count  = count_q + CW'(1);
					fin_top    = (found_idx_q > top_q) ? found_idx_q : top_q;
				end else begin
					fin_status = ST_FULL;
				end
			end
			MODE_REMOVE: begin
				if (found_q) begin
					fin_status = ST_REMOVED;
					fin_slot   = found_idx_q;
					fin_count  = count_q - CW'(1);
					if (found_idx_q == top_q) begin
						fin_top = hi_q;
					end
				end else begin
					fin_status = ST_NOTFOUND;
				end
			end
			MODE_READ: begin
				if (sidx_in_range && rd_used) begin
					fin_status = ST_HIT;
					fin_id     = mem_rdata[ID_W-1:0];
				end else begin
					fin_status = ST_EMPTY;
					fin_id     = empty_marker;
				end
			end
			MODE_CLEAR: begin
				fin_status = ST_CLEARED;
				fin_count  = '0;
				fin_top    = '0;
			end
		endcase
	end

	assign fin_slot_ext  = (AW + SLOTO_W)'(fin_slot);
	assign fin_top_ext   = (AW + SLOTO_W)'(fin_top);
	assign fin_count_ext = (CW + COUNTO_W)'(fin_count);

	// sequencer: state, walk counter, scan results and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_WIPE;
			cnt_q        <= '0;
			wipe_clear_q <= 1'b0;
			mode_q       <= MODE_ADD;
			id_q         <= '0;
			sidx_q       <= '0;
			found_q      <= 1'b0;
			dup_q        <= 1'b0;
			found_idx_q  <= '0;
			hi_q         <= '0;
			count_q      <= '0;
			top_q        <= '0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= ST_ADDED;
			slot_q       <= '0;
			id_out_q     <= '0;
			count_out_q  <= '0;
			mark_out_q   <= '0;
		end else begin
			vld_s1 <= scan_issue;
			idx_s1 <= cnt_q[AW-1:0];

			// raise the result when it is formed, drop it once it is taken
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_WIPE: begin
					if (cnt_q[AW-1:0] == LAST_C) begin
						cnt_q   <= '0;
						state_q <= wipe_clear_q ? S_FIN : S_IDLE;
					end else begin
						cnt_q <= cnt_q + (AW + 1)'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						mode_q      <= mode_t'(mode);
						id_q        <= id_value;
						sidx_q      <= slot_index;
						cnt_q       <= '0;
						found_q     <= 1'b0;
						dup_q       <= 1'b0;
						found_idx_q <= '0;
						hi_q        <= '0;
						unique case (mode_t'(mode))
							MODE_ADD, MODE_REMOVE: begin
								state_q <= S_SCAN;
							end
							MODE_READ: begin
								state_q <= S_RDWAIT;
							end
							MODE_CLEAR: begin
								wipe_clear_q <= 1'b1;
								state_q      <= S_WIPE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_issue) begin
						cnt_q <= cnt_q + (AW + 1)'(1);
					end
					if (vld_s1) begin
						if (mode_q == MODE_ADD) begin
							// note a held copy and the lowest free slot
							if (id_match) begin
								dup_q <= 1'b1;
							end
							if (!rd_used && !found_q) begin
								found_q     <= 1'b1;
								found_idx_q <= idx_s1;
							end
						end else begin
							// take the first match, track the highest other used slot
							if (id_match && !found_q) begin
								found_q     <= 1'b1;
								found_idx_q <= idx_s1;
							end else if (rd_used) begin
								hi_q <= idx_s1;
							end
						end
						if (idx_s1 == LAST_C) begin
							state_q <= S_FIN;
						end
					end
				end
				S_RDWAIT: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_fire) begin
						status_q     <= fin_status;
						slot_q       <= (mode_q == MODE_READ) ? sidx_q
							: fin_slot_ext[SLOTO_W-1:0];
						id_out_q     <= fin_id;
						count_out_q  <= fin_count_ext[COUNTO_W-1:0];
						mark_out_q   <= fin_top_ext[SLOTO_W-1:0];
						count_q      <= fin_count;
						top_q        <= fin_top;
						wipe_clear_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign slot_out    = slot_q;
	assign id_out      = id_out_q;
	assign entry_count = count_out_q;
	assign high_mark   = mark_out_q;

endmodule

// ----- rtl/isst_apb_reg.sv -----
// ----------------------------------------------------------------------------
// isst_apb_reg: configuration register block
// Holds the empty marker, written and read back over an APB-style port.
// ----------------------------------------------------------------------------
module isst_apb_reg
	import isst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [ID_W-1:0]   empty_marker
);

	logic [ID_W-1:0] marker_q;
	reg_idx_t        reg_idx;
	logic            wr_en;

	// decode the register index and the write strobe
	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;

	// hold the marker; reset to all ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= '1;
		end else if (wr_en && (reg_idx == REG_EMPTY_MARKER)) begin
			marker_q <= pwdata[ID_W-1:0];
		end
	end

	// read back the addressed register, zero elsewhere
	always_comb begin
		prdata = '0;
		if (reg_idx == REG_EMPTY_MARKER) begin
			prdata = DATA_W'(marker_q);
		end
	end

	assign empty_marker = marker_q;

endmodule

// ----- tb/sv/tb_id_set_slot_table_unit.sv -----
// ----------------------------------------------------------------------------
// tb_id_set_slot_table_unit: self-checking testbench of the ID set slot table
// Drives add, remove, read and clear transfers with random gaps and output
// stalls. A behavioral copy of the table predicts every result, and each
// result is checked field by field. The empty marker register is rewritten
// between phases through the APB port.
// ----------------------------------------------------------------------------
module tb_id_set_slot_table_unit
	import isst_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS       = 64;
	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_PCT    = 37;
	localparam int POOL_SIZE   = 96;
	localparam int PRINT_MAX   = 40;
	localparam reg_idx_t REG_UNMAPPED = reg_idx_t'(1);

	typedef struct {
		status_t                 st;
		logic [SLOTO_W-1:0]      slot;
		logic [ID_W-1:0]         id;
		logic [COUNTO_W-1:0]     count;
		logic [SLOTO_W-1:0]      mark;
	} table_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          mode = MODE_READ;
	logic [ID_W-1:0]     id_value = '0;
	logic [SLOTO_W-1:0]  slot_index = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [2:0]          status;
	logic [SLOTO_W-1:0]  slot_out;
	logic [ID_W-1:0]     id_out;
	logic [COUNTO_W-1:0] entry_count;
	logic [SLOTO_W-1:0]  high_mark;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// table copy used for prediction
	logic [ID_W-1:0] slot_ids [SLOTS];
	bit              slot_used [SLOTS];
	int              held_count;
	int              top_used;
	logic [ID_W-1:0] marker_now;

	table_result_t   pending_results [$];
	logic [ID_W-1:0] id_pool [POOL_SIZE];
	int              error_count = 0;
	int              cycle_count = 0;
	bit              calm = 1'b0;
	bit              hold_request = 1'b0;
	int              hold_left = 0;

	id_set_slot_table_unit #(.SLOTS(SLOTS)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.id_value    (id_value),
		.slot_index  (slot_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.slot_out    (slot_out),
		.id_out      (id_out),
		.entry_count (entry_count),
		.high_mark   (high_mark),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_id_set_slot_table_unit: done, errors");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_MAX)
			$display("mismatch at %0t ns: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
	endtask

	// empty every slot of the table copy
	task automatic wipe_table_copy();
		for (int i = 0; i < SLOTS; i++) begin
			slot_ids[i] = marker_now;
			slot_used[i] = 1'b0;
		end
		held_count = 0;
		top_used = 0;
	endtask

	// apply one operation to the table copy and build its result
	task automatic predict_table_op(input mode_t op, input logic [ID_W-1:0] idv,
			input logic [SLOTO_W-1:0] sidx, output table_result_t r);
		int found;
		found = -1;
		r.st = ST_ADDED;
		r.slot = '0;
		r.id = '0;
		case (op)
			MODE_ADD: begin
				// duplicates are searched among used slots only
				for (int i = 0; i < SLOTS; i++)
					if (slot_used[i] && slot_ids[i] == idv)
						found = i;
				if (found >= 0) begin
					r.st = ST_DUP;
				end else begin
					for (int i = 0; i < SLOTS && found < 0; i++)
						if (!slot_used[i])
							found = i;
					if (found < 0) begin
						r.st = ST_FULL;
					end else begin
						slot_used[found] = 1'b1;
						slot_ids[found] = idv;
						held_count++;
						if (found > top_used)
							top_used = found;
						r.slot = SLOTO_W'(found);
					end
				end
			end
			MODE_REMOVE: begin
				for (int i = 0; i < SLOTS && found < 0; i++)
					if (slot_used[i] && slot_ids[i] == idv)
						found = i;
				if (found < 0) begin
					r.st = ST_NOTFOUND;
				end else begin
					slot_used[found] = 1'b0;
					slot_ids[found] = marker_now;
					held_count--;
					// fall back to the highest slot still in use
					if (found == top_used) begin
						top_used = 0;
						for (int i = 0; i < SLOTS; i++)
							if (slot_used[i])
								top_used = i;
					end
					r.st = ST_REMOVED;
					r.slot = SLOTO_W'(found);
				end
			end
			MODE_READ: begin
				r.slot = sidx;
				if (slot_used[sidx]) begin
					r.st = ST_HIT;
					r.id = slot_ids[sidx];
				end else begin
					r.st = ST_EMPTY;
					r.id = marker_now;
				end
			end
			default: begin
				wipe_table_copy();
				r.st = ST_CLEARED;
			end
		endcase
		r.count = COUNTO_W'(held_count);
		r.mark = SLOTO_W'(top_used);
	endtask

	// offer one transfer, hold it until taken, then log its expected result
	task automatic send_op(input mode_t op, input logic [ID_W-1:0] idv,
			input logic [SLOTO_W-1:0] sidx);
		table_result_t r;
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		mode <= op;
		id_value <= idv;
		slot_index <= sidx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_table_op(op, idv, sidx, r);
		pending_results.push_back(r);
	endtask

	// drop valid and wait until every result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == REG_EMPTY_MARKER)
			marker_now = data[ID_W-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// read the marker back and compare with the copy
	task automatic check_marker_reg();
		logic [DATA_W-1:0] data;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {REG_EMPTY_MARKER, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		check_field("empty_marker readback", 32'(data[ID_W-1:0]), 32'(marker_now));
	endtask

	// output stall: random, quiet when calm, solid during a hold-off
	always @(posedge clk) begin
		if (hold_request && hold_left == 0)
			hold_left = HOLD_CYCLES;
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
			if (hold_left == 0)
				hold_request = 1'b0;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin : result_check
		table_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result, status %0d", status));
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(status), 32'(want.st));
				check_field("slot_out", 32'(slot_out), 32'(want.slot));
				check_field("id_out", 32'(id_out), 32'(want.id));
				check_field("entry_count", 32'(entry_count), 32'(want.count));
				check_field("high_mark", 32'(high_mark), 32'(want.mark));
			end
		end
	end

	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(99) < 75)
			return id_pool[$urandom_range(POOL_SIZE-1)];
		return ID_W'($urandom);
	endfunction

	// an ID currently held, or a pool or random ID when the table is empty
	function automatic logic [ID_W-1:0] pick_held_id();
		int start;
		int s;
		start = $urandom_range(SLOTS-1);
		for (int i = 0; i < SLOTS; i++) begin
			s = (start + i) % SLOTS;
			if (slot_used[s])
				return slot_ids[s];
		end
		return pick_id();
	endfunction

	// extremes, every mode and the simple corner cases
	task automatic test_directed();
		send_op(MODE_READ, 16'h0000, 6'd0);
		send_op(MODE_READ, 16'hFFFF, 6'd63);
		send_op(MODE_REMOVE, 16'h0042, 6'd0);
		send_op(MODE_ADD, 16'h0000, 6'd63);
		send_op(MODE_ADD, 16'hFFFF, 6'd0);
		send_op(MODE_ADD, 16'h1234, 6'd0);
		send_op(MODE_ADD, 16'h0000, 6'd0);
		send_op(MODE_READ, 16'h0000, 6'd1);
		send_op(MODE_REMOVE, 16'h1234, 6'd0);
		send_op(MODE_REMOVE, 16'h5555, 6'd0);
		send_op(MODE_REMOVE, 16'h0000, 6'd0);
		send_op(MODE_ADD, 16'hABCD, 6'd0);
		send_op(MODE_READ, 16'h0000, 6'd2);
		send_op(MODE_READ, 16'h0000, 6'd0);
		send_op(MODE_REMOVE, 16'hFFFF, 6'd0);
		send_op(MODE_REMOVE, 16'hABCD, 6'd0);
		send_op(MODE_ADD, 16'h8001, 6'd0);
		send_op(MODE_CLEAR, 16'hFFFF, 6'd63);
		send_op(MODE_READ, 16'h0000, 6'd0);
		send_op(MODE_ADD, 16'h7FFE, 6'd0);
		send_op(MODE_CLEAR, 16'h0000, 6'd0);
		drain_results();
	endtask

	// marker rewrites, masking of the upper data bits and the unmapped index
	task automatic test_marker_register();
		check_marker_reg();
		apb_write(REG_EMPTY_MARKER, 32'hFFFF_0000);
		apb_write(REG_UNMAPPED, 32'h0000_1234);
		check_marker_reg();
		send_op(MODE_ADD, 16'h0000, 6'd0);
		send_op(MODE_READ, 16'h0000, 6'd0);
		send_op(MODE_REMOVE, 16'h0000, 6'd0);
		send_op(MODE_READ, 16'h0000, 6'd0);
		send_op(MODE_ADD, 16'h2222, 6'd0);
		drain_results();
		apb_write(REG_EMPTY_MARKER, 32'h0000_FFFF);
		check_marker_reg();
		send_op(MODE_REMOVE, 16'h2222, 6'd0);
		send_op(MODE_READ, 16'h0000, 6'd0);
		send_op(MODE_READ, 16'h0000, 6'd63);
		drain_results();
	endtask

	// fill every slot, then hit the full, duplicate and top-removal cases
	task automatic test_fill_to_capacity();
		logic [ID_W-1:0] base;
		logic [ID_W-1:0] stride;
		base = ID_W'($urandom);
		stride = ID_W'($urandom) | 16'h0001;
		send_op(MODE_CLEAR, 16'h0000, 6'd0);
		for (int i = 0; i < SLOTS; i++)
			send_op(MODE_ADD, base + ID_W'(i) * stride, 6'd0);
		send_op(MODE_ADD, base + ID_W'(SLOTS) * stride, 6'd0);
		send_op(MODE_ADD, base, 6'd0);
		send_op(MODE_READ, 16'h0000, 6'd63);
		send_op(MODE_REMOVE, base + ID_W'(SLOTS-1) * stride, 6'd0);
		send_op(MODE_REMOVE, base + ID_W'(10) * stride, 6'd0);
		send_op(MODE_ADD, base + ID_W'(SLOTS+1) * stride, 6'd0);
		send_op(MODE_ADD, base + ID_W'(SLOTS+2) * stride, 6'd0);
		send_op(MODE_ADD, base + ID_W'(SLOTS+3) * stride, 6'd0);
		drain_results();
	endtask

	// hold the output off while transfers keep coming, so the input stalls
	task automatic test_output_holdoff();
		calm = 1'b1;
		hold_request = 1'b1;
		for (int i = 0; i < 8; i++)
			send_op(MODE_ADD, pick_id(), 6'd0);
		calm = 1'b0;
		while (hold_request)
			@(posedge clk);
		drain_results();
	endtask

	// random traffic in fill and drain spells under one marker setting
	task automatic test_random_phase(input int n_items, input logic [ID_W-1:0] marker,
			input int calm_items);
		int add_pct;
		int pick;
		logic [SLOTO_W-1:0] sidx;
		apb_write(REG_EMPTY_MARKER, {16'h0000, marker});
		check_marker_reg();
		foreach (id_pool[i])
			id_pool[i] = ID_W'($urandom);
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hFFFF;
		id_pool[2] = marker_now;
		add_pct = 60;
		for (int n = 0; n < n_items; n++) begin
			calm = (n < calm_items);
			if (n % 60 == 0)
				add_pct = ($urandom_range(1) != 0) ? 62 : 22;
			pick = $urandom_range(99);
			if (pick < 2) begin
				send_op(MODE_CLEAR, ID_W'($urandom), SLOTO_W'($urandom));
			end else if (pick < 20) begin
				sidx = ($urandom_range(1) != 0) ? SLOTO_W'($urandom_range(top_used))
					: SLOTO_W'($urandom);
				send_op(MODE_READ, ID_W'($urandom), sidx);
			end else if (pick < 20 + add_pct) begin
				send_op(MODE_ADD, ($urandom_range(9) == 0) ? pick_held_id() : pick_id(),
					SLOTO_W'($urandom));
			end else begin
				send_op(MODE_REMOVE, ($urandom_range(1) != 0) ? pick_held_id() : pick_id(),
					SLOTO_W'($urandom));
			end
		end
		calm = 1'b0;
		drain_results();
	endtask

	initial begin
		marker_now = 16'hFFFF;
		wipe_table_copy();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_marker_register();
		test_fill_to_capacity();
		test_output_holdoff();
		test_random_phase(225, 16'hFFFF, 0);
		test_random_phase(225, 16'h0000, 150);
		test_random_phase(225, ID_W'($urandom), 0);
		test_random_phase(225, 16'h8001, 0);

		// let any stray result show up
		repeat (SLOTS + 8) @(posedge clk);
		if (error_count == 0)
			$display("tb_id_set_slot_table_unit: done, clean");
		else
			$display("tb_id_set_slot_table_unit: done, errors");
		$finish;
	end

endmodule
